// ===== rtl/core/radar_rotate_scale_clamp_top_defines.svh =====
`ifndef RADAR_ROTATE_SCALE_CLAMP_TOP_DEFINES_SVH
`define RADAR_ROTATE_SCALE_CLAMP_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is applied.
`define RRSC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Overlapping implication on top of the clocked form.
`define RRSC_ASSERT_IMP(lbl, ante, cons, msg) \
	`RRSC_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/rrsc_pkg.sv =====
package rrsc_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_COS_YAW      = 3'd0;
	localparam logic [2:0] REG_SIN_YAW      = 3'd1;
	localparam logic [2:0] REG_RANGE_SCALE  = 3'd2;
	localparam logic [2:0] REG_CENTER_X     = 3'd3;
	localparam logic [2:0] REG_CENTER_Y     = 3'd4;
	localparam logic [2:0] REG_RADAR_RADIUS = 3'd5;

	localparam logic [15:0] COS_RST    = 16'd16384;
	localparam logic [15:0] SIN_RST    = 16'd0;
	localparam logic [23:0] SCALE_RST  = 24'd65536;
	localparam logic [27:0] CENTER_RST = 28'd0;
	localparam logic [26:0] RADIUS_RST = 27'd6553600;

	localparam int TRIG_FRAC   = 14;
	localparam int SCALE_FRAC  = 16;
	localparam int MAG_W       = 45;  // |rx|, |ry|
	localparam int MAXR_W      = 27;  // radius minus margin
	localparam int FIT_W       = 30;  // normalized magnitude
	localparam int SQ_W        = 62;  // radicand
	localparam int DIST_W      = 31;  // square root
	localparam int QUO_W       = 27;  // quotient bits
	localparam int NUM_W       = FIT_W + MAXR_W;
	localparam int SQRT_STAGES = DIST_W;

	typedef struct packed {
		logic             nx;
		logic             ny;
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
	} mag_t;

	typedef struct packed {
		logic             nx;
		logic             ny;
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             outside;
		logic             shifted;
		logic [FIT_W-1:0] bx;
		logic [FIT_W-1:0] by;
	} sq_side_t;

	typedef struct packed {
		logic             nx;
		logic             ny;
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             outside;
		logic             scale;
	} div_side_t;

endpackage

// ===== rtl/core/radar_rotate_scale_clamp_top.sv =====
// Radar blip mapper: rotates a 2D world offset by the viewer yaw, scales it
// to the radar, mirrors the forward axis, pulls points outside the radar edge
// (radius minus four pixels) back onto it, and adds the radar centre.
// Input channel: offset_x/offset_y are taken on a rising edge with start high
// and busy low. busy is high only while reset is applied and until the first
// clock edge after it; otherwise a new transaction can enter on every cycle.
// Output channel: result_valid strobes for exactly one cycle with screen_x,
// screen_y and clamped. The receiver cannot stall; results come out in order.
// Throughput: one transaction per cycle. The pipeline holds the 31-stage
// square root and the 27-stage dividers (one result bit per stage), plus
// 11 stages of multipliers and adders.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// cos_yaw, 1 sin_yaw, 2 range_scale, 3 center_x, 4 center_y, 5 radar_radius;
// other indexes are dropped. Write only while no transaction is in flight.
// Reset: the configuration registers return to their defaults, the valid bits
// clear so the pipeline is emptied, and any transaction in flight is dropped.
module radar_rotate_scale_clamp_top #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	output logic               result_valid,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic               clamped
);
	import rrsc_pkg::*;

	// edge margin of four pixels and the tiny-distance threshold
	localparam logic [26:0] EDGE_MARGIN = 27'(4 << COORD_FRAC_BITS);
	localparam logic [DIST_W-1:0] DIST_EPS = DIST_W'((1 << COORD_FRAC_BITS) / 1000);
	localparam logic [MAXR_W-1:0] UM_RST = (RADIUS_RST >= EDGE_MARGIN) ?
		MAXR_W'(RADIUS_RST - EDGE_MARGIN) : '0;
	localparam logic [2*MAXR_W-1:0] UM_SQ_RST = (2*MAXR_W)'(UM_RST) * (2*MAXR_W)'(UM_RST);

	// ---------------- configuration registers ----------------
	logic               rdy_q;
	logic signed [15:0] cos_q, sin_q;
	logic        [23:0] scale_q;
	logic        [27:0] cx_q, cy_q;
	logic        [26:0] radius_q;
	logic [MAXR_W-1:0]   um_q;
	logic [2*MAXR_W-1:0] um_sq_q;

	assign busy      = !rdy_q;
	assign cfg_ready = rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q    <= 1'b0;
			cos_q    <= COS_RST;
			sin_q    <= SIN_RST;
			scale_q  <= SCALE_RST;
			cx_q     <= CENTER_RST;
			cy_q     <= CENTER_RST;
			radius_q <= RADIUS_RST;
			um_q     <= UM_RST;
			um_sq_q  <= UM_SQ_RST;
		end else begin
			rdy_q <= 1'b1;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COS_YAW:      cos_q    <= cfg_data[15:0];
					REG_SIN_YAW:      sin_q    <= cfg_data[15:0];
					REG_RANGE_SCALE:  scale_q  <= cfg_data[23:0];
					REG_CENTER_X:     cx_q     <= cfg_data[27:0];
					REG_CENTER_Y:     cy_q     <= cfg_data[27:0];
					REG_RADAR_RADIUS: radius_q <= cfg_data[26:0];
					default: ;
				endcase
			end
			// derived clamp radius (um_q) and its square (um_sq_q), registered in turn from radius_q
			um_q    <= (radius_q >= EDGE_MARGIN) ? MAXR_W'(radius_q - EDGE_MARGIN) : '0;
			um_sq_q <= (2*MAXR_W)'(um_q) * (2*MAXR_W)'(um_q);
		end
	end

	// ---------------- stages 1-4: rotate and scale ----------------
	logic rs_valid;
	mag_t rs_mag;

	rrsc_rotscale u_rotscale (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.dx          (offset_x),
		.dy          (offset_y),
		.cos_yaw     (cos_q),
		.sin_yaw     (sin_q),
		.range_scale (scale_q),
		.out_valid   (rs_valid),
		.out_mag     (rs_mag)
	);

	// ---------------- stage 5: edge test terms, normalize shift ----------------
	logic                v_s5;
	mag_t                mag_s5;
	logic                bigx_s5, bigy_s5;
	logic [2*MAXR_W-1:0] sqx_s5, sqy_s5;
	logic [3:0]          sh_s5;
	logic [MAG_W-1:0]    mor;
	logic [3:0]          sh;

	// smallest shift that brings both magnitudes below 2^FIT_W
	always_comb begin
		mor = rs_mag.ax | rs_mag.ay;
		sh  = '0;
		for (int k = 0; k < MAG_W - FIT_W; k++) begin
			if (mor[FIT_W + k]) begin
				sh = 4'(k + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s5  <= rs_mag;
		bigx_s5 <= rs_mag.ax > MAG_W'(um_q);
		bigy_s5 <= rs_mag.ay > MAG_W'(um_q);
		sqx_s5  <= (2*MAXR_W)'(rs_mag.ax[MAXR_W-1:0]) * (2*MAXR_W)'(rs_mag.ax[MAXR_W-1:0]);
		sqy_s5  <= (2*MAXR_W)'(rs_mag.ay[MAXR_W-1:0]) * (2*MAXR_W)'(rs_mag.ay[MAXR_W-1:0]);
		sh_s5   <= sh;
	end

	// ---------------- stage 6: outside decision, shift ----------------
	logic     v_s6;
	sq_side_t side_s6;

	always_ff @(posedge clk) begin
		side_s6.nx      <= mag_s5.nx;
		side_s6.ny      <= mag_s5.ny;
		side_s6.ax      <= mag_s5.ax;
		side_s6.ay      <= mag_s5.ay;
		side_s6.outside <= bigx_s5 || bigy_s5 ||
			(({1'b0, sqx_s5} + {1'b0, sqy_s5}) > {1'b0, um_sq_q});
		side_s6.shifted <= sh_s5 != '0;
		side_s6.bx      <= FIT_W'(mag_s5.ax >> sh_s5);
		side_s6.by      <= FIT_W'(mag_s5.ay >> sh_s5);
	end

	// ---------------- stages 7-8: squared distance ----------------
	logic               v_s7, v_s8;
	sq_side_t           side_s7, side_s8;
	logic [2*FIT_W-1:0] bsqx_s7, bsqy_s7;
	logic [SQ_W-1:0]    rad_s8;

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		bsqx_s7 <= (2*FIT_W)'(side_s6.bx) * (2*FIT_W)'(side_s6.bx);
		bsqy_s7 <= (2*FIT_W)'(side_s6.by) * (2*FIT_W)'(side_s6.by);
		side_s8 <= side_s7;
		rad_s8  <= SQ_W'(bsqx_s7) + SQ_W'(bsqy_s7);
	end

	// ---------------- stages 9-39: square root ----------------
	logic              sq_valid;
	logic [DIST_W-1:0] sq_root;
	sq_side_t          sq_side;

	rrsc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.radicand  (rad_s8),
		.in_side   (side_s8),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// ---------------- stage 40: numerators ----------------
	logic              v_s40;
	logic [NUM_W-1:0]  numx_s40, numy_s40;
	logic [DIST_W-1:0] den_s40;
	div_side_t         dside_s40;

	always_ff @(posedge clk) begin
		numx_s40        <= NUM_W'(sq_side.bx) * NUM_W'(um_q);
		numy_s40        <= NUM_W'(sq_side.by) * NUM_W'(um_q);
		den_s40         <= sq_root;
		dside_s40.nx    <= sq_side.nx;
		dside_s40.ny    <= sq_side.ny;
		dside_s40.ax    <= sq_side.ax;
		dside_s40.ay    <= sq_side.ay;
		dside_s40.outside <= sq_side.outside;
		// a tiny distance without any normalize shift is left unscaled
		dside_s40.scale <= sq_side.outside && (sq_side.shifted || (sq_root > DIST_EPS));
	end

	// ---------------- stages 41-67: divide ----------------
	logic             dv_valid;
	logic [QUO_W-1:0] dv_qx, dv_qy;
	div_side_t        dv_side;

	rrsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s40),
		.num_x     (numx_s40),
		.num_y     (numy_s40),
		.den       (den_s40),
		.in_side   (dside_s40),
		.out_valid (dv_valid),
		.quo_x     (dv_qx),
		.quo_y     (dv_qy),
		.out_side  (dv_side)
	);

	// ---------------- stage 68: pick magnitude, restore sign ----------------
	logic                    v_s68;
	logic signed [MAG_W:0]   valx_s68, valy_s68;
	logic                    clamp_s68;
	logic        [MAG_W-1:0] magx, magy;

	always_comb begin
		magx = dv_side.scale ? MAG_W'(dv_qx) : dv_side.ax;
		magy = dv_side.scale ? MAG_W'(dv_qy) : dv_side.ay;
	end

	always_ff @(posedge clk) begin
		valx_s68  <= dv_side.nx ? -signed'({1'b0, magx}) : signed'({1'b0, magx});
		valy_s68  <= dv_side.ny ? -signed'({1'b0, magy}) : signed'({1'b0, magy});
		clamp_s68 <= dv_side.outside;
	end

	// ---------------- stage 69: add centre, saturate ----------------
	logic               v_s69;
	logic signed [31:0] sx_s69, sy_s69;
	logic               clamp_s69;
	logic signed [MAG_W+1:0] sumx, sumy;
	logic signed [31:0] satx, saty;

	always_comb begin
		sumx = (MAG_W+2)'(valx_s68) + signed'((MAG_W+2)'(cx_q));
		sumy = (MAG_W+2)'(valy_s68) + signed'((MAG_W+2)'(cy_q));
		if (sumx[MAG_W+1:31] == {(MAG_W-29){sumx[MAG_W+1]}}) begin
			satx = sumx[31:0];
		end else begin
			satx = sumx[MAG_W+1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		if (sumy[MAG_W+1:31] == {(MAG_W-29){sumy[MAG_W+1]}}) begin
			saty = sumy[31:0];
		end else begin
			saty = sumy[MAG_W+1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk) begin
		sx_s69    <= satx;
		sy_s69    <= saty;
		clamp_s69 <= clamp_s68;
	end

	// valid bits travel with the data; no back-pressure, so always advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s40 <= 1'b0;
			v_s68 <= 1'b0;
			v_s69 <= 1'b0;
		end else begin
			v_s5  <= rs_valid;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s40 <= sq_valid;
			v_s68 <= dv_valid;
			v_s69 <= v_s68;
		end
	end

	assign result_valid = v_s69;
	assign screen_x     = sx_s69;
	assign screen_y     = sy_s69;
	assign clamped      = clamp_s69;

endmodule

// ===== rtl/core/rrsc_rotscale.sv =====
module rrsc_rotscale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [31:0] dx,
	input  logic signed [31:0] dy,
	input  logic signed [15:0] cos_yaw,
	input  logic signed [15:0] sin_yaw,
	input  logic        [23:0] range_scale,
	output logic               out_valid,
	output rrsc_pkg::mag_t     out_mag
);
	import rrsc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [47:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	logic signed [34:0] fwd_s2, rgt_s2;
	logic signed [59:0] rxp_s3;
	logic signed [60:0] ryp_s3;
	mag_t mag_s4;

	logic signed [48:0] fsum, rsum;
	logic signed [35:0] nfwd;
	logic signed [24:0] sc_s;
	logic [MAG_W-1:0] rx, ry;

	always_comb begin
		fsum = 49'(pxc_s1) + 49'(pys_s1);
		rsum = 49'(pxs_s1) - 49'(pyc_s1);
		nfwd = -36'(fwd_s2);
		sc_s = signed'({1'b0, range_scale});
		rx   = {rxp_s3[59], rxp_s3[59:SCALE_FRAC]};
		ry   = ryp_s3[60:SCALE_FRAC];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pxc_s1 <= dx * cos_yaw;
		pys_s1 <= dy * sin_yaw;
		pxs_s1 <= dx * sin_yaw;
		pyc_s1 <= dy * cos_yaw;
		fwd_s2 <= fsum[48:TRIG_FRAC];
		rgt_s2 <= rsum[48:TRIG_FRAC];
		rxp_s3 <= rgt_s2 * sc_s;
		ryp_s3 <= nfwd * sc_s;
		mag_s4.nx <= rx[MAG_W-1];
		mag_s4.ny <= ry[MAG_W-1];
		mag_s4.ax <= rx[MAG_W-1] ? -rx : rx;
		mag_s4.ay <= ry[MAG_W-1] ? -ry : ry;
	end

	assign out_valid = v_s4;
	assign out_mag   = mag_s4;

endmodule

// ===== rtl/core/rrsc_isqrt.sv =====
module rrsc_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rrsc_pkg::SQ_W-1:0]     radicand,
	input  rrsc_pkg::sq_side_t            in_side,
	output logic                          out_valid,
	output logic [rrsc_pkg::DIST_W-1:0]   root,
	output rrsc_pkg::sq_side_t            out_side
);
	import rrsc_pkg::*;

	logic [SQRT_STAGES-1:0] v_s;
	logic [SQ_W-1:0] rem_s  [SQRT_STAGES];
	logic [SQ_W-1:0] root_s [SQRT_STAGES];
	sq_side_t        side_s [SQRT_STAGES];

	logic [SQ_W-1:0] rem_in  [SQRT_STAGES];
	logic [SQ_W-1:0] root_in [SQRT_STAGES];
	logic [SQ_W-1:0] trial   [SQRT_STAGES];
	logic [SQ_W-1:0] rem_nx  [SQRT_STAGES];
	logic [SQ_W-1:0] root_nx [SQRT_STAGES];

	// one result bit per stage, trial bit walks down two places a stage
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_step
		localparam logic [SQ_W-1:0] BIT_G = SQ_W'(1) << (2 * (SQRT_STAGES - 1 - g));
		if (g == 0) begin : g_first
			assign rem_in[g]  = radicand;
			assign root_in[g] = '0;
		end else begin : g_next
			assign rem_in[g]  = rem_s[g-1];
			assign root_in[g] = root_s[g-1];
		end
		assign trial[g]   = root_in[g] + BIT_G;
		assign rem_nx[g]  = (rem_in[g] >= trial[g]) ? rem_in[g] - trial[g] : rem_in[g];
		assign root_nx[g] = (rem_in[g] >= trial[g]) ? (root_in[g] >> 1) + BIT_G
		                                            : root_in[g] >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[SQRT_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int i = 1; i < SQRT_STAGES; i++) begin
			side_s[i] <= side_s[i-1];
		end
		for (int i = 0; i < SQRT_STAGES; i++) begin
			rem_s[i]  <= rem_nx[i];
			root_s[i] <= root_nx[i];
		end
	end

	assign out_valid = v_s[SQRT_STAGES-1];
	assign root      = root_s[SQRT_STAGES-1][DIST_W-1:0];
	assign out_side  = side_s[SQRT_STAGES-1];

endmodule

// ===== rtl/core/rrsc_div.sv =====
module rrsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rrsc_pkg::NUM_W-1:0]    num_x,
	input  logic [rrsc_pkg::NUM_W-1:0]    num_y,
	input  logic [rrsc_pkg::DIST_W-1:0]   den,
	input  rrsc_pkg::div_side_t           in_side,
	output logic                          out_valid,
	output logic [rrsc_pkg::QUO_W-1:0]    quo_x,
	output logic [rrsc_pkg::QUO_W-1:0]    quo_y,
	output rrsc_pkg::div_side_t           out_side
);
	import rrsc_pkg::*;

	logic [QUO_W-1:0]  v_s;
	logic [DIST_W-1:0] remx_s [QUO_W];
	logic [DIST_W-1:0] remy_s [QUO_W];
	logic [QUO_W-1:0]  lox_s  [QUO_W];
	logic [QUO_W-1:0]  loy_s  [QUO_W];
	logic [DIST_W-1:0] den_s  [QUO_W];
	div_side_t         side_s [QUO_W];

	logic [DIST_W-1:0] remx_in [QUO_W];
	logic [DIST_W-1:0] remy_in [QUO_W];
	logic [QUO_W-1:0]  lox_in  [QUO_W];
	logic [QUO_W-1:0]  loy_in  [QUO_W];
	logic [DIST_W-1:0] den_in  [QUO_W];
	logic [DIST_W:0]   candx   [QUO_W];
	logic [DIST_W:0]   candy   [QUO_W];
	logic [QUO_W-1:0]  gex, gey;

	// restoring division, one quotient bit per stage; the quotient
	// shifts into the low numerator bits as they are consumed
	for (genvar g = 0; g < QUO_W; g++) begin : g_step
		if (g == 0) begin : g_first
			assign remx_in[g] = DIST_W'(num_x[NUM_W-1:QUO_W]);
			assign remy_in[g] = DIST_W'(num_y[NUM_W-1:QUO_W]);
			assign lox_in[g]  = num_x[QUO_W-1:0];
			assign loy_in[g]  = num_y[QUO_W-1:0];
			assign den_in[g]  = den;
		end else begin : g_next
			assign remx_in[g] = remx_s[g-1];
			assign remy_in[g] = remy_s[g-1];
			assign lox_in[g]  = lox_s[g-1];
			assign loy_in[g]  = loy_s[g-1];
			assign den_in[g]  = den_s[g-1];
		end
		assign candx[g] = {remx_in[g], lox_in[g][QUO_W-1]};
		assign candy[g] = {remy_in[g], loy_in[g][QUO_W-1]};
		assign gex[g]   = candx[g] >= {1'b0, den_in[g]};
		assign gey[g]   = candy[g] >= {1'b0, den_in[g]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[QUO_W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		for (int i = 1; i < QUO_W; i++) begin
			side_s[i] <= side_s[i-1];
		end
		for (int i = 0; i < QUO_W; i++) begin
			remx_s[i] <= gex[i] ? DIST_W'(candx[i] - {1'b0, den_in[i]}) : candx[i][DIST_W-1:0];
			remy_s[i] <= gey[i] ? DIST_W'(candy[i] - {1'b0, den_in[i]}) : candy[i][DIST_W-1:0];
			lox_s[i]  <= {lox_in[i][QUO_W-2:0], gex[i]};
			loy_s[i]  <= {loy_in[i][QUO_W-2:0], gey[i]};
			den_s[i]  <= den_in[i];
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign quo_x     = lox_s[QUO_W-1];
	assign quo_y     = loy_s[QUO_W-1];
	assign out_side  = side_s[QUO_W-1];

endmodule

// ===== rtl/core/rrsc_checker.sv =====
`include "radar_rotate_scale_clamp_top_defines.svh"

module rrsc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic result_valid
);
	localparam int LATENCY = 69;

	// every accepted transaction gives exactly one strobe, a fixed time later
	`RRSC_ASSERT_IMP(a_result_follows, start && !busy, ##LATENCY result_valid, "result missing after accepted transaction")
	`RRSC_ASSERT_IMP(a_result_has_source, result_valid, $past(start && !busy, LATENCY), "result without matching transaction")
	// configuration writes land only once the block is out of reset
	`RRSC_ASSERT_IMP(a_cfg_when_ready, cfg_valid && cfg_ready, !busy, "config taken while input side busy")

endmodule

bind radar_rotate_scale_clamp_top rrsc_checker u_rrsc_checker (.*);
